@@ design/mset_pkg.sv @@
// Shared types and constants for the semaphore table.
package mset_pkg;

    localparam int HANDLE_W = 16;
    localparam int PID_W    = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_CREATE_MUTEX = 3'd0,
        OP_CREATE_EVENT = 3'd1,
        OP_REQUEST      = 3'd2,
        OP_CLEAR        = 3'd3,
        OP_SET          = 3'd4,
        OP_CLOSE        = 3'd5
    } t_op;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_BAD_ID    = 3'd1;
    localparam logic [2:0] STS_NO_PROC   = 3'd2;
    localparam logic [2:0] STS_BUSY      = 3'd3;
    localparam logic [2:0] STS_UNLOCKED  = 3'd4;
    localparam logic [2:0] STS_NOT_OWNER = 3'd5;
    localparam logic [2:0] STS_FULL      = 3'd6;
    localparam logic [2:0] STS_SET_MUTEX = 3'd7;

    typedef enum logic [2:0] {
        CMD_CREATE,
        CMD_REQUEST,
        CMD_CLEAR,
        CMD_SET,
        CMD_CLOSE,
        CMD_BAD
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_PICK,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [2:0]          op;
        logic [HANDLE_W-1:0] sem_handle;
        logic                start_unlocked;
        logic [PID_W-1:0]    caller_pid;
        logic                caller_valid;
    } t_in_item;

    typedef struct packed {
        logic [2:0]          status;
        logic [HANDLE_W-1:0] new_handle;
    } t_out_item;

    typedef struct packed {
        t_cmd                cmd;
        logic                is_event;
        logic                start_unlocked;
        logic [HANDLE_W-1:0] handle;
        logic [PID_W-1:0]    pid;
        logic                pid_valid;
    } t_job;

endpackage

@@ design/mset_front.sv @@
// Front end: accepts items, decodes the operation and hands jobs to the queue.
module mset_front import mset_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_item,
    output logic     o_push,
    output t_job     o_job,
    input  logic     i_q_full
);

    logic r_valid;
    logic n_valid;
    t_job r_job;
    t_job n_job;
    logic accept;

    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;
    assign o_job      = r_job;

    always_comb begin
        n_job.is_event       = 1'b0;
        n_job.start_unlocked = i_in_item.start_unlocked;
        n_job.handle         = i_in_item.sem_handle;
        n_job.pid            = i_in_item.caller_pid;
        n_job.pid_valid      = i_in_item.caller_valid;
        case (i_in_item.op)
            OP_CREATE_MUTEX: n_job.cmd = CMD_CREATE;
            OP_CREATE_EVENT: begin
                n_job.cmd      = CMD_CREATE;
                n_job.is_event = 1'b1;
            end
            OP_REQUEST:      n_job.cmd = CMD_REQUEST;
            OP_CLEAR:        n_job.cmd = CMD_CLEAR;
            OP_SET:          n_job.cmd = CMD_SET;
            OP_CLOSE:        n_job.cmd = CMD_CLOSE;
            default:         n_job.cmd = CMD_BAD;
        endcase
    end

    assign n_valid = accept || (r_valid && i_q_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

@@ design/mset_queue.sv @@
// Two-entry job queue between the front end and the execution unit.
module mset_queue import mset_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ design/mset_back.sv @@
// Execution unit: slot table, id lookup, read-modify-write and result register.
module mset_back import mset_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic                r_used     [NUM_SLOTS];
    logic [HANDLE_W-1:0] r_handle   [NUM_SLOTS];
    logic                r_is_event [NUM_SLOTS];
    logic                r_locked   [NUM_SLOTS];
    logic [PID_W-1:0]    r_owner    [NUM_SLOTS];
    logic [HANDLE_W-1:0] r_next_handle;

    t_state              r_state;
    t_state              n_state;
    t_job                r_job;
    logic [NUM_SLOTS-1:0] r_vec;
    logic [NUM_SLOTS-1:0] n_vec;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    n_idx;
    logic                r_found;
    logic                n_found;
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic      match_en;
    logic      pick_en;
    logic      fire;
    logic      out_free;

    t_out_item res;
    logic      wr_create;
    logic      wr_free;
    logic      wr_locked_en;
    logic      wr_locked_val;
    logic      wr_owner_en;
    logic [PID_W-1:0] wr_owner_val;

    logic             cur_event;
    logic             cur_locked;
    logic [PID_W-1:0] cur_owner;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = i_q_valid ? S_MATCH : S_IDLE;
            S_MATCH: n_state = S_PICK;
            S_PICK:  n_state = S_EXEC;
            S_EXEC:  n_state = out_free ? S_IDLE : S_EXEC;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        match_en = 1'b0;
        pick_en  = 1'b0;
        fire     = 1'b0;
        case (r_state)
            S_IDLE:  o_pop    = i_q_valid;
            S_MATCH: match_en = 1'b1;
            S_PICK:  pick_en  = 1'b1;
            S_EXEC:  fire     = out_free;
            default: ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (r_job.cmd == CMD_CREATE) begin
                n_vec[i] = !r_used[i];
            end else begin
                n_vec[i] = r_used[i] && (r_handle[i] == r_job.handle);
            end
        end
    end

    always_comb begin
        n_idx   = '0;
        n_found = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_vec[i]) begin
                n_idx   = IDX_W'(i);
                n_found = 1'b1;
            end
        end
    end

    assign cur_event  = r_is_event[r_idx];
    assign cur_locked = r_locked[r_idx];
    assign cur_owner  = r_owner[r_idx];

    always_comb begin
        res.status     = STS_BAD_ID;
        res.new_handle = '0;
        wr_create      = 1'b0;
        wr_free        = 1'b0;
        wr_locked_en   = 1'b0;
        wr_locked_val  = 1'b0;
        wr_owner_en    = 1'b0;
        wr_owner_val   = '0;
        case (r_job.cmd)
            CMD_CREATE: begin
                if (!r_found) begin
                    res.status = STS_FULL;
                end else begin
                    res.status     = STS_OK;
                    res.new_handle = r_next_handle;
                    wr_create      = 1'b1;
                end
            end
            CMD_REQUEST: begin
                if (r_found) begin
                    if (!r_job.pid_valid) begin
                        res.status = STS_NO_PROC;
                    end else if (cur_event) begin
                        res.status = cur_locked ? STS_BUSY : STS_OK;
                    end else if (!cur_locked) begin
                        res.status    = STS_OK;
                        wr_locked_en  = 1'b1;
                        wr_locked_val = 1'b1;
                        wr_owner_en   = 1'b1;
                        wr_owner_val  = r_job.pid;
                    end else begin
                        res.status = STS_BUSY;
                    end
                end
            end
            CMD_CLEAR: begin
                if (r_found) begin
                    if (!r_job.pid_valid) begin
                        res.status = STS_NO_PROC;
                    end else if (cur_event) begin
                        res.status    = STS_OK;
                        wr_locked_en  = 1'b1;
                        wr_locked_val = 1'b1;
                    end else if (cur_locked && cur_owner == r_job.pid) begin
                        res.status   = STS_OK;
                        wr_locked_en = 1'b1;
                        wr_owner_en  = 1'b1;
                    end else if (!cur_locked) begin
                        res.status = STS_UNLOCKED;
                    end else begin
                        res.status = STS_NOT_OWNER;
                    end
                end
            end
            CMD_SET: begin
                if (r_found) begin
                    if (!cur_event) begin
                        res.status = STS_SET_MUTEX;
                    end else begin
                        res.status   = STS_OK;
                        wr_locked_en = 1'b1;
                    end
                end
            end
            CMD_CLOSE: begin
                if (r_found) begin
                    res.status = STS_OK;
                    wr_free    = 1'b1;
                end
            end
            default: res.status = STS_BAD_ID;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_next_handle <= HANDLE_W'(1);
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_used[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (fire && wr_create) begin
                r_used[r_idx] <= 1'b1;
                r_next_handle <= (r_next_handle == '1) ? HANDLE_W'(1)
                                                       : r_next_handle + HANDLE_W'(1);
            end
            if (fire && wr_free) begin
                r_used[r_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (match_en) begin
            r_vec <= n_vec;
        end
        if (pick_en) begin
            r_idx   <= n_idx;
            r_found <= n_found;
        end
        if (fire) begin
            r_out_item <= res;
            if (wr_create) begin
                r_handle[r_idx]   <= r_next_handle;
                r_is_event[r_idx] <= r_job.is_event;
                r_locked[r_idx]   <= !r_job.start_unlocked;
                r_owner[r_idx]    <= '0;
            end
            if (wr_free) begin
                r_handle[r_idx] <= '0;
            end
            if (wr_locked_en) begin
                r_locked[r_idx] <= wr_locked_val;
            end
            if (wr_owner_en) begin
                r_owner[r_idx] <= wr_owner_val;
            end
        end
    end

endmodule

@@ design/mutex_event_semaphore_table.sv @@
// Top level of the mutex and event semaphore table.
// The execution unit takes one item at a time through its fetch, compare,
// priority-select and read-modify-write sequence, and does not take the next
// item from the queue until the last one's result is registered.
// Reset: synchronous active-low; clears all slots, empties the queue and
// sets the next id to 1. Items are accepted in the first cycle after reset.
module mutex_event_semaphore_table import mset_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic push;
    t_job front_job;
    logic q_full;
    logic q_valid;
    t_job q_job;
    logic pop;

    mset_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_push     (push),
        .o_job      (front_job),
        .i_q_full   (q_full)
    );

    mset_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    mset_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

@@ design/mset_checker.sv @@
// Port-level checks for the semaphore table, bound to the top level.
module mset_checker import mset_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs not idle after reset");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_item))
        else $error("stalled input item changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_handle_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.new_handle != '0 |-> o_out_item.status == STS_OK)
        else $error("new id given with a failing status");

    a_full_no_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == STS_FULL |-> o_out_item.new_handle == '0)
        else $error("full table returned an id");

endmodule

bind mutex_event_semaphore_table mset_checker u_mset_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
